[rtl/core/circular_deque_assert.svh]
// Assertion macros for the deque block.
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH

// Check the consequent in the same cycle as the antecedent.
`define CDQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define CDQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/cdq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

	localparam int DEPTH  = 16;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;

	typedef logic [1:0] op_t;
	typedef logic [1:0] status_t;

	localparam op_t OP_PUSH_FRONT = 2'd0;
	localparam op_t OP_PUSH_BACK  = 2'd1;
	localparam op_t OP_POP_FRONT  = 2'd2;
	localparam op_t OP_POP_BACK   = 2'd3;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_EMPTY = 2'd2;

endpackage

`default_nettype wire

[rtl/core/cdq_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module cdq_ram #(
	parameter int DATA_W = 32,
	parameter int ADDR_W = 4
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [DATA_W-1:0] rd_data
);

	localparam int WORDS = 1 << ADDR_W;

	logic [DATA_W-1:0] mem_q [WORDS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

[rtl/core/circular_deque.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "circular_deque_assert.svh"

// Double-ended queue of signed 32-bit words in a ring of DEPTH entries.
// Command channel: drive operation and value and raise start; the command
// transfers at a rising edge where start is high and busy is low.
// Result channel: done is high for exactly one cycle and qualifies status,
// popped_value, front_value, back_value and occupancy in that cycle. The
// receiver cannot stall; every result must be taken when done is high.
// Pushes, rejected commands and pops that empty the ring register done in the
// cycle after the transfer, and busy stays low, so they run one per cycle. A
// pop that leaves words behind reads the new end word from the ring memory,
// whose read is registered; busy is high for one cycle in the S_READ state,
// which lands the word and raises done, and no command transfers meanwhile.
// The front and back words are held in registers beside the memory.
// Reset: the ring is empty, head and count are zero, no result is pending;
// the memory contents are not cleared and are read only after being written.
module circular_deque
	import cdq_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [1:0]               operation,
	input  wire logic signed [WORD_W-1:0] value,
	output logic                          done,
	output logic [1:0]                    status,
	output logic signed [WORD_W-1:0]      popped_value,
	output logic signed [WORD_W-1:0]      front_value,
	output logic signed [WORD_W-1:0]      back_value,
	output logic [CNT_W-1:0]              occupancy
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_READ = 1'b1;

	logic                     state_q;
	logic [ADDR_W-1:0]        head_q;
	logic [CNT_W-1:0]         count_q;
	logic signed [WORD_W-1:0] front_q;
	logic signed [WORD_W-1:0] back_q;
	logic                     done_q;
	status_t                  status_q;
	logic signed [WORD_W-1:0] popped_q;
	logic                     pend_front_q;

	logic                     xfer;
	logic                     is_push;
	logic                     is_front;
	logic                     full;
	logic                     empty;
	logic                     wr_en;
	logic [ADDR_W-1:0]        wr_addr;
	logic                     rd_en;
	logic [ADDR_W-1:0]        rd_addr;
	logic [WORD_W-1:0]        rd_data;

	assign busy     = (state_q == S_READ);
	assign xfer     = start && !busy;
	assign is_push  = operation inside {OP_PUSH_FRONT, OP_PUSH_BACK};
	assign is_front = operation inside {OP_PUSH_FRONT, OP_POP_FRONT};
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);

	always_comb begin
		wr_en   = xfer && is_push && !full;
		wr_addr = '0;
		if (!empty) begin
			wr_addr = is_front ? head_q - 1'b1 : head_q + count_q[ADDR_W-1:0];
		end
		rd_en   = xfer && !is_push && (count_q > CNT_W'(1));
		rd_addr = is_front ? head_q + 1'b1 : head_q + count_q[ADDR_W-1:0] - ADDR_W'(2);
	end

	cdq_ram #(
		.DATA_W(WORD_W),
		.ADDR_W(ADDR_W)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(value),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			count_q      <= '0;
			front_q      <= '0;
			back_q       <= '0;
			done_q       <= 1'b0;
			status_q     <= ST_OK;
			popped_q     <= '0;
			pend_front_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (state_q == S_READ) begin
				// land the new end word from the ring
				state_q <= S_IDLE;
				done_q  <= 1'b1;
				if (count_q == CNT_W'(1)) begin
					front_q <= rd_data;
					back_q  <= rd_data;
				end else if (pend_front_q) begin
					front_q <= rd_data;
				end else begin
					back_q <= rd_data;
				end
			end else if (xfer) begin
				popped_q <= '0;
				status_q <= ST_OK;
				if (is_push) begin
					if (full) begin
						status_q <= ST_FULL;
						done_q   <= 1'b1;
					end else begin
						count_q <= count_q + 1'b1;
						done_q  <= 1'b1;
						if (empty) begin
							head_q  <= '0;
							front_q <= value;
							back_q  <= value;
						end else if (is_front) begin
							head_q  <= head_q - 1'b1;
							front_q <= value;
						end else begin
							back_q <= value;
						end
					end
				end else if (empty) begin
					status_q <= ST_EMPTY;
					done_q   <= 1'b1;
				end else begin
					popped_q     <= is_front ? front_q : back_q;
					count_q      <= count_q - 1'b1;
					pend_front_q <= is_front;
					if (is_front) begin
						head_q <= head_q + 1'b1;
					end
					if (count_q == CNT_W'(1)) begin
						front_q <= '0;
						back_q  <= '0;
						done_q  <= 1'b1;
					end else begin
						state_q <= S_READ;
					end
				end
			end
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign popped_value = popped_q;
	assign front_value  = front_q;
	assign back_value   = back_q;
	assign occupancy    = count_q;

	`CDQ_ASSERT_NOW(a_count_range, 1'b1, count_q <= CNT_W'(DEPTH), "count exceeds depth")
	`CDQ_ASSERT_NEXT(a_read_done, busy, done && !busy, "ring read did not finish a pop")
	`CDQ_ASSERT_NOW(a_full_occ, done && (status == ST_FULL), occupancy == CNT_W'(DEPTH), "full reject with room left")
	`CDQ_ASSERT_NOW(a_empty_occ, done && (status == ST_EMPTY), occupancy == '0, "empty reject with words held")
	`CDQ_ASSERT_NOW(a_empty_ends, !busy && (count_q == '0), (front_q == '0) && (back_q == '0), "ends not cleared when empty")

endmodule

`default_nettype wire
